// ===== rtl/color_space_converter_top_defines.svh =====
// ----------------------------------------------------------------------------
// color space converter assertion macros
// shared assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef COLOR_SPACE_CONVERTER_TOP_DEFINES_SVH
`define COLOR_SPACE_CONVERTER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CCV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CCV_ASSERT_IMPL(lbl, ante, cons, msg) \
  `CCV_ASSERT(lbl, (ante) |-> (cons), msg)
`else
`define CCV_ASSERT(lbl, prop, msg)
`define CCV_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/ccv_pkg.sv =====
// ----------------------------------------------------------------------------
// ccv_pkg
// shared constants and types of the color space converter
// ----------------------------------------------------------------------------
package ccv_pkg;

  localparam int FRAC_BITS = 15;

  localparam logic [1:0] SP_RGB  = 2'd0;
  localparam logic [1:0] SP_CMYK = 2'd1;
  localparam logic [1:0] SP_HSB  = 2'd2;
  localparam logic [1:0] SP_GRAY = 2'd3;

  localparam int HUE_SECTORS = 6;
  localparam int GRAY_W_R    = 30;
  localparam int GRAY_W_G    = 59;
  localparam int GRAY_W_B    = 11;
  localparam int GRAY_DIV    = 100;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_HSB,
    MODE_GRAY_RGB,
    MODE_GRAY_CMYK
  } mode_t;

endpackage

// ===== rtl/ccv_front.sv =====
// ----------------------------------------------------------------------------
// ccv_front
// input clamp, hsb/rgb products and divider operand setup, three stages
// ----------------------------------------------------------------------------
module ccv_front #(
  parameter int FRAC_BITS = ccv_pkg::FRAC_BITS,
  localparam int CW = FRAC_BITS + 1,
  localparam int DW = FRAC_BITS + 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          source_space,
  input  logic [1:0]          target_space,
  input  logic [15:0]         in_c0,
  input  logic [15:0]         in_c1,
  input  logic [15:0]         in_c2,
  input  logic [15:0]         in_c3,
  output logic                out_valid,
  output ccv_pkg::mode_t      mode,
  output logic                unsup,
  output logic                achrom,
  output logic [CW-1:0]       cand0,
  output logic [CW-1:0]       cand1,
  output logic [CW-1:0]       cand2,
  output logic [CW-1:0]       cand3,
  output logic [DW-1:0]       num_a,
  output logic [DW-1:0]       den_a,
  output logic [DW-1:0]       num_b,
  output logic [DW-1:0]       den_b
);

  localparam int IW = (CW > 16) ? CW : 16;
  localparam int PW = 2 * CW;
  localparam int HW = FRAC_BITS + 3;
  localparam logic [IW-1:0] ONE_I = IW'(1) << FRAC_BITS;
  localparam logic [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;

  // stage a: clamp
  logic          va;
  logic [1:0]    src_a, dst_a;
  logic [CW-1:0] a0, a1, a2, a3;

  function automatic logic [CW-1:0] clamp_in(input logic [15:0] x);
    logic [IW-1:0] w;
    w = IW'(x);
    return (w > ONE_I) ? ONE_C : CW'(w);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= in_valid;
    end
    src_a <= source_space;
    dst_a <= target_space;
    a0 <= clamp_in(in_c0);
    a1 <= clamp_in(in_c1);
    a2 <= clamp_in(in_c2);
    a3 <= clamp_in(in_c3);
  end

  // stage b: first products, extremes, hue numerator, gray sum
  logic [HW-1:0]       h6;
  logic [FRAC_BITS-1:0] frac;
  logic [PW-1:0]       p_sf, p_sk, p_m;
  logic [CW-1:0]       mx, mn, dif;
  logic [DW-1:0]       hnum, gsum;

  always_comb begin
    h6   = HW'(a0) * HW'(ccv_pkg::HUE_SECTORS);
    frac = h6[FRAC_BITS-1:0];
    p_sf = PW'(a1) * PW'(frac);
    p_sk = PW'(a1) * PW'(ONE_C - CW'(frac));
    p_m  = PW'(a2) * PW'(ONE_C - a1);
    mx = (a0 > a1) ? a0 : a1;
    mn = (a0 > a1) ? a1 : a0;
    if (a2 > mx) mx = a2;
    if (a2 < mn) mn = a2;
    dif = mx - mn;
    if (mx == a0) begin
      if (a1 >= a2) hnum = DW'(a1 - a2);
      else hnum = DW'(dif) * DW'(ccv_pkg::HUE_SECTORS) - DW'(a2 - a1);
    end else if (mx == a1) begin
      hnum = (DW'(dif) << 1) + DW'(a2) - DW'(a0);
    end else begin
      hnum = (DW'(dif) << 2) + DW'(a0) - DW'(a1);
    end
    gsum = DW'(a0) * DW'(ccv_pkg::GRAY_W_R) + DW'(a1) * DW'(ccv_pkg::GRAY_W_G)
         + DW'(a2) * DW'(ccv_pkg::GRAY_W_B);
  end

  logic          vb, ach_b;
  logic [1:0]    src_b, dst_b;
  logic [CW-1:0] b0, b1, b2, b3;
  logic [2:0]    sector_b;
  logic [CW-1:0] ps_b, pk_b, pm_b, mx_b, dif_b;
  logic [DW-1:0] hnum_b, gsum_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
    src_b    <= src_a;
    dst_b    <= dst_a;
    b0       <= a0;
    b1       <= a1;
    b2       <= a2;
    b3       <= a3;
    sector_b <= h6[HW-1:FRAC_BITS];
    ps_b     <= CW'(p_sf >> FRAC_BITS);
    pk_b     <= CW'(p_sk >> FRAC_BITS);
    pm_b     <= CW'(p_m >> FRAC_BITS);
    mx_b     <= mx;
    dif_b    <= dif;
    hnum_b   <= hnum;
    gsum_b   <= gsum;
    ach_b    <= (a0 == a1) && (a1 == a2);
  end

  // stage c: second products, candidate components, divider operands
  logic [PW-1:0]      p_n, p_k;
  logic [CW-1:0]      n_v, k_v;
  logic [CW:0]        s0, s1, s2;
  logic [CW-1:0]      c0_n, c1_n, c2_n, c3_n;
  ccv_pkg::mode_t     mode_next;
  logic               unsup_next;
  logic [DW-1:0]      nb_next, db_next;

  function automatic logic [CW-1:0] inv_sat(input logic [CW:0] s);
    return (s > (CW+1)'(ONE_C)) ? '0 : CW'((CW+1)'(ONE_C) - s);
  endfunction

  always_comb begin
    p_n = PW'(b2) * PW'(ONE_C - ps_b);
    p_k = PW'(b2) * PW'(ONE_C - pk_b);
    n_v = CW'(p_n >> FRAC_BITS);
    k_v = CW'(p_k >> FRAC_BITS);
    s0 = (CW+1)'(b0) + (CW+1)'(b3);
    s1 = (CW+1)'(b1) + (CW+1)'(b3);
    s2 = (CW+1)'(b2) + (CW+1)'(b3);
    c0_n = b0;
    c1_n = b1;
    c2_n = b2;
    c3_n = b3;
    mode_next  = ccv_pkg::MODE_PASS;
    unsup_next = 1'b0;
    nb_next = gsum_b;
    db_next = DW'(ONE_C) * DW'(ccv_pkg::GRAY_DIV);
    if (src_b != dst_b) begin
      unique case (dst_b)
        ccv_pkg::SP_RGB: begin
          if (src_b == ccv_pkg::SP_CMYK) begin
            c0_n = inv_sat(s0);
            c1_n = inv_sat(s1);
            c2_n = inv_sat(s2);
          end else if (src_b == ccv_pkg::SP_HSB) begin
            if (b1 == '0) begin
              c0_n = b2; c1_n = b2; c2_n = b2;
            end else begin
              unique case (sector_b)
                3'd1: begin c0_n = n_v;  c1_n = b2;   c2_n = pm_b; end
                3'd2: begin c0_n = pm_b; c1_n = b2;   c2_n = k_v;  end
                3'd3: begin c0_n = pm_b; c1_n = n_v;  c2_n = b2;   end
                3'd4: begin c0_n = k_v;  c1_n = pm_b; c2_n = b2;   end
                3'd5: begin c0_n = b2;   c1_n = pm_b; c2_n = n_v;  end
                default: begin c0_n = b2; c1_n = k_v; c2_n = pm_b; end
              endcase
            end
          end else begin
            c1_n = b0; c2_n = b0;
          end
        end
        ccv_pkg::SP_CMYK: begin
          if (src_b == ccv_pkg::SP_RGB) begin
            c0_n = ONE_C - b0;
            c1_n = ONE_C - b1;
            c2_n = ONE_C - b2;
            c3_n = '0;
          end else if (src_b == ccv_pkg::SP_HSB) begin
            unsup_next = 1'b1;
          end else begin
            c3_n = ONE_C - b0;
            c0_n = '0; c1_n = '0; c2_n = '0;
          end
        end
        ccv_pkg::SP_HSB: begin
          if (src_b == ccv_pkg::SP_RGB) begin
            mode_next = ccv_pkg::MODE_HSB;
            c2_n = mx_b;
            nb_next = DW'(dif_b);
            db_next = DW'(mx_b);
          end else if (src_b == ccv_pkg::SP_CMYK) begin
            unsup_next = 1'b1;
          end else begin
            c2_n = b0;
            c0_n = '0; c1_n = '0;
          end
        end
        default: begin
          if (src_b == ccv_pkg::SP_RGB) mode_next = ccv_pkg::MODE_GRAY_RGB;
          else if (src_b == ccv_pkg::SP_CMYK) mode_next = ccv_pkg::MODE_GRAY_CMYK;
          else c0_n = b2;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vb;
    end
    mode   <= mode_next;
    unsup  <= unsup_next;
    achrom <= ach_b;
    cand0  <= c0_n;
    cand1  <= c1_n;
    cand2  <= c2_n;
    cand3  <= c3_n;
    num_a  <= hnum_b;
    den_a  <= DW'(dif_b) * DW'(ccv_pkg::HUE_SECTORS);
    num_b  <= nb_next;
    den_b  <= db_next;
  end

endmodule

// ===== rtl/ccv_divider.sv =====
// ----------------------------------------------------------------------------
// ccv_divider
// pipelined restoring divider, one quotient bit per stage, for num <= den
// ----------------------------------------------------------------------------
module ccv_divider #(
  parameter int DW = 22,
  parameter int QN = 16,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          vin,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic          vout,
  output logic [QN-1:0] quo,
  output logic [TW-1:0] tag_out
);

  logic [DW:0]   rem_s [QN];
  logic [DW-1:0] den_s [QN];
  logic [QN-1:0] quo_s [QN];
  logic [TW-1:0] tag_s [QN];
  logic [QN-1:0] val_s;

  for (genvar i = 0; i < QN; i++) begin : g_stage
    logic [DW:0]   trial;
    logic [DW-1:0] d_in;
    logic [QN-1:0] q_in, q_next;
    logic [TW-1:0] t_in;
    logic          v_in, ge;

    if (i == 0) begin : g_first
      assign trial = {1'b0, num};
      assign d_in  = den;
      assign q_in  = '0;
      assign t_in  = tag_in;
      assign v_in  = vin;
    end else begin : g_next
      assign trial = {rem_s[i-1][DW-1:0], 1'b0};
      assign d_in  = den_s[i-1];
      assign q_in  = quo_s[i-1];
      assign t_in  = tag_s[i-1];
      assign v_in  = val_s[i-1];
    end

    always_comb begin
      ge = trial >= {1'b0, d_in};
      q_next = q_in;
      q_next[QN-1-i] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        val_s[i] <= 1'b0;
      end else begin
        val_s[i] <= v_in;
      end
      rem_s[i] <= ge ? (trial - {1'b0, d_in}) : trial;
      den_s[i] <= d_in;
      quo_s[i] <= q_next;
      tag_s[i] <= t_in;
    end
  end

  assign vout    = val_s[QN-1];
  assign quo     = quo_s[QN-1];
  assign tag_out = tag_s[QN-1];

endmodule

// ===== rtl/color_space_converter_top.sv =====
// ----------------------------------------------------------------------------
// color_space_converter_top
// converts a four-component Q1.15 color between rgb, cmyk, hsb and gray
// ----------------------------------------------------------------------------
// A new item is taken on every clock in which start is high; busy is always
// low. Each item's result appears with done high for one cycle, in the order
// the items came in. The receiver cannot stall the block and none is needed.
// Every item passes through the hue and saturation dividers (the rgb-to-hsb
// divisions; the saturation divider also does the gray division), which are
// pipelined with one quotient bit per stage, behind three stages of clamping
// and multiplication and ahead of one output stage.
`include "color_space_converter_top_defines.svh"

module color_space_converter_top #(
  parameter int FRAC_BITS = ccv_pkg::FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  source_space,
  input  logic [1:0]  target_space,
  input  logic [15:0] in_c0,
  input  logic [15:0] in_c1,
  input  logic [15:0] in_c2,
  input  logic [15:0] in_c3,
  output logic        done,
  output logic [15:0] out_c0,
  output logic [15:0] out_c1,
  output logic [15:0] out_c2,
  output logic [15:0] out_c3,
  output logic        unsupported
);

  localparam int CW  = FRAC_BITS + 1;
  localparam int DW  = FRAC_BITS + 7;
  localparam int IW  = (CW > 16) ? CW : 16;
  localparam int TW  = 3 + 4 * CW;
  localparam int LAT = CW + 4;
  localparam logic [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;
  localparam logic [15:0] OUT_MAX = (CW > 16) ? 16'hFFFF : 16'(ONE_C);

  logic           fv, f_unsup, f_ach;
  ccv_pkg::mode_t f_mode;
  logic [CW-1:0]  f_c0, f_c1, f_c2, f_c3;
  logic [DW-1:0]  f_na, f_da, f_nb, f_db;

  assign busy = 1'b0;

  ccv_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (start),
    .source_space (source_space),
    .target_space (target_space),
    .in_c0        (in_c0),
    .in_c1        (in_c1),
    .in_c2        (in_c2),
    .in_c3        (in_c3),
    .out_valid    (fv),
    .mode         (f_mode),
    .unsup        (f_unsup),
    .achrom       (f_ach),
    .cand0        (f_c0),
    .cand1        (f_c1),
    .cand2        (f_c2),
    .cand3        (f_c3),
    .num_a        (f_na),
    .den_a        (f_da),
    .num_b        (f_nb),
    .den_b        (f_db)
  );

  logic          va, vb;
  logic [CW-1:0] qa, qb;
  logic          t_unsup;
  logic [TW-1:0] tb;

  ccv_divider #(.DW(DW), .QN(CW), .TW(1)) u_div_hue (
    .clk     (clk),
    .rst     (rst),
    .vin     (fv),
    .num     (f_na),
    .den     (f_da),
    .tag_in  (f_unsup),
    .vout    (va),
    .quo     (qa),
    .tag_out (t_unsup)
  );

  ccv_divider #(.DW(DW), .QN(CW), .TW(TW)) u_div_sat (
    .clk     (clk),
    .rst     (rst),
    .vin     (fv),
    .num     (f_nb),
    .den     (f_db),
    .tag_in  ({f_ach, f_mode, f_c0, f_c1, f_c2, f_c3}),
    .vout    (vb),
    .quo     (qb),
    .tag_out (tb)
  );

  logic           t_ach;
  logic [1:0]     t_mode_raw;
  ccv_pkg::mode_t t_mode;
  logic [CW-1:0]  t_c0, t_c1, t_c2, t_c3;
  logic [CW:0]    gk;
  logic [CW-1:0]  r0, r1;

  assign {t_ach, t_mode_raw, t_c0, t_c1, t_c2, t_c3} = tb;
  assign t_mode = ccv_pkg::mode_t'(t_mode_raw);

  function automatic logic [15:0] sat16(input logic [CW-1:0] x);
    logic [IW-1:0] w;
    w = IW'(x);
    return (w > IW'(16'hFFFF)) ? 16'hFFFF : w[15:0];
  endfunction

  always_comb begin
    gk = (CW+1)'(qb) + (CW+1)'(t_c3);
    r0 = t_c0;
    r1 = t_c1;
    unique case (t_mode)
      ccv_pkg::MODE_HSB: begin
        r0 = t_ach ? '0 : qa;
        r1 = t_ach ? '0 : qb;
      end
      ccv_pkg::MODE_GRAY_RGB: r0 = qb;
      ccv_pkg::MODE_GRAY_CMYK:
        r0 = (gk > (CW+1)'(ONE_C)) ? '0 : CW'((CW+1)'(ONE_C) - gk);
      default: r0 = t_c0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= 1'b0;
      unsupported <= 1'b0;
    end else begin
      done        <= vb;
      unsupported <= vb & t_unsup;
    end
    out_c0 <= sat16(r0);
    out_c1 <= sat16(r1);
    out_c2 <= sat16(t_c2);
    out_c3 <= sat16(t_c3);
  end

  `CCV_ASSERT(a_lanes_aligned, (va == vb), "divider lanes out of step")
  `CCV_ASSERT_IMPL(a_latency, done, $past(start, LAT), "result without item")
  `CCV_ASSERT_IMPL(a_unsup_done, unsupported, done, "flag outside result")
  `CCV_ASSERT_IMPL(a_range, done, (out_c0 <= OUT_MAX) && (out_c1 <= OUT_MAX), "out of range")

endmodule
